// File: design/lru_page_cache_table_assert.svh
// Assertion macros shared by the LRU page cache table RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef LRU_PAGE_CACHE_TABLE_ASSERT_SVH
`define LRU_PAGE_CACHE_TABLE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define LPCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Cause in one cycle, effect in the next.
`define LPCT_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

// File: design/lpct_pkg.sv
// Package for the LRU page cache table: payload structs, codes and cell control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lpct_pkg;

  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 7;
  localparam int CTR_W   = 32;
  localparam int BUMP_W  = 11;

  localparam logic [CTR_W-1:0] START_SLOT = 32'd777;

  typedef enum logic [2:0] {
    CMD_LOOKUP = 3'd0,
    CMD_PUT    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_EVICT  = 3'd3,
    CMD_TOUCH  = 3'd4,
    CMD_PIN    = 3'd5
  } lpct_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } lpct_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } lpct_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FRONT,
    OP_DROP,
    OP_TOUCH,
    OP_PIN
  } lpct_op_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [ADDR_W-1:0] page_address;
    logic              keep;
    logic [BUMP_W-1:0] bump;
    logic              pin_value;
  } lpct_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  found_address;
    logic [CTR_W-1:0]   counter_value;
    logic [COUNT_W-1:0] entry_count;
  } lpct_out_t;

  typedef struct packed {
    logic              valid;
    logic              pin;
    logic [ADDR_W-1:0] addr;
    logic [CTR_W-1:0]  count;
  } lpct_entry_t;

  typedef struct packed {
    lpct_op_t         op;
    logic             scale;
    logic             pin_value;
    logic [CTR_W-1:0] wcount;
  } lpct_ctl_t;

endpackage
`default_nettype wire

// File: design/lpct_cell.sv
// One recency position of the table: holds the entry of a fixed rank.
// Depends on lpct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpct_cell import lpct_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IW    = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  lpct_ctl_t         ctl,
  input  logic [IW-1:0]     idx,
  input  logic [ADDR_W-1:0] key,
  input  lpct_entry_t       left,
  input  lpct_entry_t       right,
  output lpct_entry_t       q,
  output logic              match,
  output logic              evictable
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  lpct_entry_t entry;

  assign q         = entry;
  assign match     = entry.valid && (entry.addr == key);
  assign evictable = entry.valid && !entry.pin;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      entry.pin   <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_FRONT: begin
          if (MY_IDX <= idx) begin
            entry <= left;
          end
        end
        OP_DROP: begin
          if (MY_IDX >= idx) begin
            entry <= right;
          end
        end
        OP_TOUCH: begin
          if (MY_IDX == idx) begin
            entry.count <= ctl.wcount;
          end else if (ctl.scale && entry.valid) begin
            entry.count <= entry.count >> 16;
          end
        end
        OP_PIN: begin
          if (MY_IDX == idx) begin
            entry.pin <= ctl.pin_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/lru_page_cache_table.sv
// Top level of the LRU page cache table: control sequencer and a row of cells.
// Depends on lpct_pkg, lpct_cell and lru_page_cache_table_assert.svh.
//
//   channel   direction   handshake                  payload
//   in        into block  in_valid / in_ready        in_data  (lpct_in_t)
//   out       from block  out_valid / out_ready      out_data (lpct_out_t)
//
// Each transaction is captured, then compared in parallel across all cells with
// priority encoding, and then applied as an update to the row.
// The update waits while a previous result sits unclaimed in the output register.
// A new transaction is captured while the result of the last one still waits.
// Reset clears every cell's valid and pinned marks, the entry count and sets the
// time slot to 777; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module lru_page_cache_table import lpct_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lpct_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lpct_out_t out_data
);

  `include "lru_page_cache_table_assert.svh"

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Ranks run from the head (position 0, newest) to the tail.
  lpct_entry_t cells [ENTRIES];
  lpct_entry_t lefts [ENTRIES];
  lpct_entry_t rights[ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] evict_vec;
  logic [ENTRIES-1:0] valid_vec;

  lpct_state_t state, state_next;
  lpct_in_t    req;
  logic        hit, hit_next;
  logic        ev_ok, ev_ok_next;
  logic [IW-1:0] hidx, hidx_next;
  logic [IW-1:0] eidx, eidx_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CTR_W-1:0] ts, ts_next;
  lpct_out_t   res_next;
  logic        apply_en;

  lpct_ctl_t   ctl;
  logic [IW-1:0] op_idx;
  lpct_entry_t head;

  // Row of cells. Each cell sees its neighbors toward the head and the tail;
  // the head cell's left neighbor is the entry being inserted.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = head;
    end else begin : g_mid
      assign lefts[i] = cells[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign rights[i] = '{valid: 1'b0, pin: 1'b0, addr: cells[i].addr,
                           count: cells[i].count};
    end else begin : g_body
      assign rights[i] = cells[i+1];
    end
    assign valid_vec[i] = cells[i].valid;

    lpct_cell #(.INDEX(i), .IW(IW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .idx       (op_idx),
      .key       (req.page_address),
      .left      (lefts[i]),
      .right     (rights[i]),
      .q         (cells[i]),
      .match     (match_vec[i]),
      .evictable (evict_vec[i])
    );
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_MATCH;
      S_MATCH: state_next = S_APPLY;
      S_APPLY: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = (state == S_IDLE);
    apply_en = (state == S_APPLY) && (!out_valid || out_ready);
  end

  // Priority encoding of the compare results. The hit is unique; the eviction
  // victim is the unpinned entry nearest the tail.
  always_comb begin
    hit_next   = |match_vec;
    ev_ok_next = |evict_vec;
    hidx_next  = '0;
    eidx_next  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) hidx_next = IW'(i);
      if (evict_vec[i]) eidx_next = IW'(i);
    end
  end

  // Command execution: picks the row operation and forms the result.
  logic [CTR_W:0]   over_sum;
  logic [CTR_W:0]   round_sum;
  logic [CTR_W-1:0] ts_base;
  logic [CTR_W-1:0] ts_inc;
  logic [CTR_W-1:0] touch_count;

  always_comb begin
    over_sum    = {1'b0, ts} + (CTR_W+1)'(1024) + (CTR_W+1)'(req.bump);
    round_sum   = {1'b0, ts} + (CTR_W+1)'(16'hFFFF);
    ts_base     = over_sum[CTR_W] ? CTR_W'(round_sum[CTR_W:16]) : ts;
    ts_inc      = ts_base + 1'b1;
    touch_count = ts_inc + CTR_W'(req.bump);

    ctl      = '{op: OP_NONE, scale: 1'b0, pin_value: req.pin_value, wcount: touch_count};
    op_idx   = hidx;
    head     = cells[hidx];
    head.valid = 1'b1;
    cnt_next = cnt;
    ts_next  = ts;
    res_next = '{status: ST_MISS, found_address: '0, counter_value: '0,
                 entry_count: '0};

    unique case (lpct_cmd_t'(req.command))
      CMD_LOOKUP, CMD_REMOVE: begin
        if (hit) begin
          res_next.status        = ST_DONE;
          res_next.found_address = req.page_address;
          res_next.counter_value = cells[hidx].count;
          if (lpct_cmd_t'(req.command) == CMD_LOOKUP && req.keep) begin
            ctl.op = OP_FRONT;
          end else begin
            ctl.op   = OP_DROP;
            cnt_next = cnt - 1'b1;
          end
        end
      end
      CMD_PUT: begin
        if (hit) begin
          ctl.op                 = OP_FRONT;
          res_next.status        = ST_DONE;
          res_next.found_address = req.page_address;
          res_next.counter_value = cells[hidx].count;
        end else if (cnt == CW'(ENTRIES)) begin
          res_next.status = ST_FULL;
        end else begin
          // A new entry enters at the head; the first free position takes
          // the old tail.
          ctl.op                 = OP_FRONT;
          op_idx                 = cnt[IW-1:0];
          head                   = '{valid: 1'b1, pin: 1'b0,
                                     addr: req.page_address, count: '0};
          cnt_next               = cnt + 1'b1;
          res_next.status        = ST_DONE;
          res_next.found_address = req.page_address;
        end
      end
      CMD_EVICT: begin
        if (ev_ok) begin
          ctl.op                 = OP_DROP;
          op_idx                 = eidx;
          cnt_next               = cnt - 1'b1;
          res_next.status        = ST_DONE;
          res_next.found_address = cells[eidx].addr;
          res_next.counter_value = cells[eidx].count;
        end
      end
      CMD_TOUCH: begin
        if (hit) begin
          // Near overflow every counter and the time slot are scaled down first.
          ctl.op                 = OP_TOUCH;
          ctl.scale              = over_sum[CTR_W];
          ts_next                = ts_inc;
          res_next.status        = ST_DONE;
          res_next.found_address = req.page_address;
          res_next.counter_value = touch_count;
        end
      end
      CMD_PIN: begin
        if (hit) begin
          ctl.op                 = OP_PIN;
          res_next.status        = ST_DONE;
          res_next.found_address = req.page_address;
          res_next.counter_value = cells[hidx].count;
        end
      end
      default: begin
      end
    endcase
    res_next.entry_count = COUNT_W'(cnt_next);
    if (!apply_en) begin
      ctl.op = OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ts        <= START_SLOT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        req <= in_data;
      end
      if (state == S_MATCH) begin
        hit   <= hit_next;
        ev_ok <= ev_ok_next;
        hidx  <= hidx_next;
        eidx  <= eidx_next;
      end
      if (apply_en) begin
        cnt       <= cnt_next;
        ts        <= ts_next;
        out_data  <= res_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LPCT_ASSERT(a_cnt_bound, cnt <= CW'(ENTRIES), "entry count above capacity")
  `LPCT_ASSERT(a_cnt_valid, $countones(valid_vec) == int'(cnt),
               "valid cells disagree with entry count")
  `LPCT_ASSERT(a_unique_hit, (state != S_MATCH) || $onehot0(match_vec),
               "address held in more than one cell")
  `LPCT_ASSERT_NEXT(a_result_out, apply_en, out_valid, "applied command left no result")

endmodule
`default_nettype wire

// File: dv/lru_page_cache_table_checker.sv
// Checker for the LRU page cache table: watches both channels, predicts each result.
// Depends on lpct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lru_page_cache_table_checker import lpct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  lpct_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  lpct_out_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int DEPTH = 64;

  logic              used [DEPTH];
  logic [ADDR_W-1:0] addr_of [DEPTH];
  int unsigned       rank_of [DEPTH];
  logic [CTR_W-1:0]  hits_of [DEPTH];
  logic              pinned [DEPTH];
  logic [CTR_W-1:0]  clock_slot;
  int unsigned       occupancy;

  lpct_out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic int find_page(logic [ADDR_W-1:0] a);
    for (int i = 0; i < DEPTH; i++)
      if (used[i] && addr_of[i] == a) return i;
    return -1;
  endfunction

  function automatic void unlink(int s);
    for (int i = 0; i < DEPTH; i++)
      if (used[i] && rank_of[i] > rank_of[s]) rank_of[i]--;
    used[s] = 1'b0;
    pinned[s] = 1'b0;
    if (occupancy > 0) occupancy--;
  endfunction

  function automatic void promote(int s);
    for (int i = 0; i < DEPTH; i++)
      if (used[i] && rank_of[i] < rank_of[s]) rank_of[i]++;
    rank_of[s] = 0;
  endfunction

  // Applies one transaction to the shadow table and returns the result it causes.
  function automatic lpct_out_t apply_command(lpct_in_t t);
    lpct_out_t r;
    int s;
    int best;
    longint unsigned wide;
    r = '0;
    r.status = ST_MISS;
    s = find_page(t.page_address);
    case (t.command)
      CMD_LOOKUP: if (s >= 0) begin
        r.status = ST_DONE;
        r.found_address = t.page_address;
        r.counter_value = hits_of[s];
        if (t.keep) promote(s);
        else unlink(s);
      end
      CMD_PUT: begin
        if (s >= 0) begin
          promote(s);
          r.status = ST_DONE;
          r.found_address = t.page_address;
          r.counter_value = hits_of[s];
        end else if (occupancy >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          best = 0;
          while (used[best]) best++;
          for (int j = 0; j < DEPTH; j++)
            if (used[j]) rank_of[j]++;
          used[best] = 1'b1;
          addr_of[best] = t.page_address;
          rank_of[best] = 0;
          hits_of[best] = '0;
          pinned[best] = 1'b0;
          occupancy++;
          r.status = ST_DONE;
          r.found_address = t.page_address;
        end
      end
      CMD_REMOVE: if (s >= 0) begin
        r.status = ST_DONE;
        r.found_address = t.page_address;
        r.counter_value = hits_of[s];
        unlink(s);
      end
      CMD_EVICT: begin
        best = -1;
        for (int i = 0; i < DEPTH; i++)
          if (used[i] && !pinned[i] && (best < 0 || rank_of[i] > rank_of[best]))
            best = i;
        if (best >= 0) begin
          r.status = ST_DONE;
          r.found_address = addr_of[best];
          r.counter_value = hits_of[best];
          unlink(best);
        end
      end
      CMD_TOUCH: if (s >= 0) begin
        // Rescale everything first when the slot is close to wrapping.
        if (longint'(clock_slot) > 64'hFFFF_FFFF - 1024 - longint'(t.bump)) begin
          for (int i = 0; i < DEPTH; i++)
            if (used[i]) hits_of[i] = hits_of[i] >> 16;
          wide = (longint'(clock_slot) + 64'hFFFF) >> 16;
          clock_slot = wide[CTR_W-1:0];
        end
        clock_slot = clock_slot + 1;
        hits_of[s] = clock_slot + CTR_W'(t.bump);
        r.status = ST_DONE;
        r.found_address = t.page_address;
        r.counter_value = hits_of[s];
      end
      CMD_PIN: if (s >= 0) begin
        pinned[s] = t.pin_value;
        r.status = ST_DONE;
        r.found_address = t.page_address;
        r.counter_value = hits_of[s];
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(occupancy);
    return r;
  endfunction

  always @(posedge clk) begin
    lpct_out_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        used[i] <= 1'b0;
        pinned[i] <= 1'b0;
        addr_of[i] <= '0;
        rank_of[i] <= 0;
        hits_of[i] <= '0;
      end
      clock_slot <= START_SLOT;
      occupancy <= 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) expected_results.push_back(apply_command(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            if (out_data.status !== want.status)
              $error("status: expected %0d, got %0d", want.status, out_data.status);
            if (out_data.found_address !== want.found_address)
              $error("found_address: expected %h, got %h",
                     want.found_address, out_data.found_address);
            if (out_data.counter_value !== want.counter_value)
              $error("counter_value: expected %h, got %h",
                     want.counter_value, out_data.counter_value);
            if (out_data.entry_count !== want.entry_count)
              $error("entry_count: expected %0d, got %0d",
                     want.entry_count, out_data.entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Top of the LRU page cache table testbench: clock, reset, stimulus and verdict.
// Depends on lpct_pkg, lru_page_cache_table and lru_page_cache_table_checker.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import lpct_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  lpct_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lpct_out_t out_data;
  int        fail_count;
  int        pending;
  bit        stimulus_done;
  bit        hold_output;

  // Pool of page addresses that the random part reuses, so that hits are common.
  logic [ADDR_W-1:0] page_pool[$];

  lru_page_cache_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  lru_page_cache_table_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] random_address();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Offers one transaction, after a random gap when gaps is set, and holds it until it is taken.
  task automatic send(lpct_cmd_t c, logic [ADDR_W-1:0] a, logic k,
                      logic [BUMP_W-1:0] b, logic p, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    repeat (gap) @(negedge clk);
    in_data.command = c;
    in_data.page_address = a;
    in_data.keep = k;
    in_data.bump = b;
    in_data.pin_value = p;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random(int mode);
    lpct_cmd_t c;
    logic [ADDR_W-1:0] a;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) c = CMD_PUT;
    else if (pick < 50) c = CMD_LOOKUP;
    else if (pick < 60) c = CMD_REMOVE;
    else if (pick < 72) c = CMD_EVICT;
    else if (pick < 88) c = CMD_TOUCH;
    else if (pick < 97) c = CMD_PIN;
    else c = lpct_cmd_t'($urandom_range(6, 7));
    if ($urandom_range(0, 9) < 8 && page_pool.size() > 0)
      a = page_pool[$urandom_range(0, page_pool.size() - 1)];
    else
      a = random_address();
    send(c, a, 1'($urandom_range(0, 1)),
         ($urandom_range(0, 3) == 0) ? BUMP_W'($urandom()) : BUMP_W'($urandom_range(0, 1024)),
         1'($urandom_range(0, 1)), mode != 0);
  endtask

  // Receiver: random stall per result, with a long hold-off when requested.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_output) begin
        out_ready = 1'b0;
        while (hold_output) @(negedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      out_ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    hold_output = 1'b0;
    stimulus_done = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: misses on an empty table, address extremes, pinning,
    // touch with the largest bump, lookup with and without keep, bad codes.
    send(CMD_EVICT, '0, 1'b0, '0, 1'b0, 0);
    send(CMD_LOOKUP, '0, 1'b1, '0, 1'b0, 0);
    send(CMD_PUT, '0, 1'b0, '0, 1'b0, 0);
    send(CMD_PUT, '1, 1'b0, '0, 1'b0, 0);
    send(CMD_PUT, 48'h5555_5555_5555, 1'b0, '0, 1'b0, 0);
    send(CMD_PUT, '0, 1'b0, '0, 1'b0, 0);
    send(CMD_TOUCH, '1, 1'b0, '1, 1'b0, 0);
    send(CMD_TOUCH, '0, 1'b0, 11'd1024, 1'b0, 0);
    send(CMD_TOUCH, 48'h1234, 1'b0, 11'd5, 1'b0, 0);
    send(CMD_PIN, '0, 1'b0, '0, 1'b1, 0);
    send(CMD_PIN, '1, 1'b0, '0, 1'b1, 0);
    send(CMD_PIN, 48'h5555_5555_5555, 1'b0, '0, 1'b1, 0);
    send(CMD_EVICT, '0, 1'b0, '0, 1'b0, 0);
    send(CMD_PIN, '1, 1'b0, '0, 1'b0, 0);
    send(CMD_EVICT, '0, 1'b0, '0, 1'b0, 0);
    send(CMD_LOOKUP, '0, 1'b1, '0, 1'b0, 0);
    send(CMD_LOOKUP, 48'h5555_5555_5555, 1'b0, '0, 1'b0, 0);
    send(CMD_REMOVE, '0, 1'b0, '0, 1'b0, 0);
    send(CMD_REMOVE, '0, 1'b0, '0, 1'b0, 0);
    send(lpct_cmd_t'(3'd6), '1, 1'b1, '1, 1'b1, 0);
    send(lpct_cmd_t'(3'd7), '0, 1'b0, '0, 1'b0, 0);

    // Fill the table past its 64 entries so the full status shows up.
    for (int i = 0; i < 66; i++) begin
      page_pool.push_back(random_address());
      send(CMD_PUT, page_pool[i], 1'b0, '0, 1'b0, 1);
    end

    // Long receiver hold-off while the sender keeps offering transactions.
    hold_output = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_output = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_random(0);
    join

    // Random part: bursts without gaps are mixed with gapped stretches.
    // The time slot grows by one per touch, so rescaling near overflow is not
    // reachable in a run of this length.
    for (int n = 0; n < 600; n += burst) begin
      burst = $urandom_range(5, 40);
      for (int i = 0; i < burst; i++) send_random(n % 3);
      if ($urandom_range(0, 4) == 0) begin
        page_pool.delete();
        for (int i = 0; i < 80; i++) page_pool.push_back(random_address());
      end
    end
    stimulus_done = 1'b1;
  end

  // Verdict once everything has drained, plus a slack wait.
  initial begin
    wait (stimulus_done);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && !out_valid) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
